### design/dsdc_pkg.sv
package dsdc_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int SERIAL_W = 22;

    // days-before-year and accumulator width (covers base count plus serial)
    localparam int DBY_W    = 23;

    // defaults
    localparam int MAX_YEAR_DEF  = 9999;
    localparam int BASE_YEAR_RST = 1;

    // year lengths and month count
    localparam int DAYS_COMMON = 365;
    localparam int DAYS_LEAP   = 366;
    localparam int MONTHS      = 12;
    localparam int YLEN_W      = 9;

    // divide by 25 through a reciprocal: exact for a 12-bit dividend
    localparam int Q4_W        = YEAR_W - 2;
    localparam int Q100_W      = 8;
    localparam int R25_W       = 5;
    localparam int DIV25_MUL   = 1311;
    localparam int DIV25_SHIFT = 15;
    localparam int PROD_W      = 23;
    localparam int CENTURY_R25 = 24;

    // year unit control and result
    typedef struct packed {
        logic stage_a;
        logic stage_b;
    } yu_ctrl_t;

    typedef struct packed {
        logic [DBY_W-1:0] dby;
        logic             leap;
    } yu_res_t;

    // microcode
    localparam int OP_W = 4;
    localparam int PC_W = 5;

    localparam logic [OP_W-1:0] OP_LD_YEAR = 4'd0;
    localparam logic [OP_W-1:0] OP_YA      = 4'd1;
    localparam logic [OP_W-1:0] OP_YB      = 4'd2;
    localparam logic [OP_W-1:0] OP_D_CHK   = 4'd3;
    localparam logic [OP_W-1:0] OP_LD_BASE = 4'd4;
    localparam logic [OP_W-1:0] OP_D_SUB   = 4'd5;
    localparam logic [OP_W-1:0] OP_S_INIT  = 4'd6;
    localparam logic [OP_W-1:0] OP_S_TGT   = 4'd7;
    localparam logic [OP_W-1:0] OP_S_TEST  = 4'd8;
    localparam logic [OP_W-1:0] OP_S_UPD   = 4'd9;
    localparam logic [OP_W-1:0] OP_S_LDLO  = 4'd10;
    localparam logic [OP_W-1:0] OP_S_REM   = 4'd11;
    localparam logic [OP_W-1:0] OP_S_CHK   = 4'd12;
    localparam logic [OP_W-1:0] OP_S_MON   = 4'd13;
    localparam logic [OP_W-1:0] OP_FIN     = 4'd14;

    localparam logic [1:0] JMP_NEXT   = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_FLAG   = 2'd2;

    localparam logic [PC_W-1:0] PC_D_ENTRY = 5'd0;
    localparam logic [PC_W-1:0] PC_S_ENTRY = 5'd8;
    localparam logic [PC_W-1:0] PC_S_TEST  = 5'd12;
    localparam logic [PC_W-1:0] PC_S_EXIT  = 5'd16;
    localparam logic [PC_W-1:0] PC_S_MON   = 5'd21;
    localparam logic [PC_W-1:0] PC_FIN     = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
    } ucw_t;

    // control store
    function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
        ucw_t cw;
        case (pc)
            // date to serial
            5'd0:  cw = '{OP_LD_YEAR, JMP_NEXT,   PC_FIN};
            5'd1:  cw = '{OP_YA,      JMP_NEXT,   PC_FIN};
            5'd2:  cw = '{OP_YB,      JMP_NEXT,   PC_FIN};
            5'd3:  cw = '{OP_D_CHK,   JMP_FLAG,   PC_FIN};
            5'd4:  cw = '{OP_LD_BASE, JMP_NEXT,   PC_FIN};
            5'd5:  cw = '{OP_YA,      JMP_NEXT,   PC_FIN};
            5'd6:  cw = '{OP_YB,      JMP_NEXT,   PC_FIN};
            5'd7:  cw = '{OP_D_SUB,   JMP_ALWAYS, PC_FIN};
            // serial to date: base count and target
            5'd8:  cw = '{OP_S_INIT,  JMP_FLAG,   PC_FIN};
            5'd9:  cw = '{OP_YA,      JMP_NEXT,   PC_FIN};
            5'd10: cw = '{OP_YB,      JMP_NEXT,   PC_FIN};
            5'd11: cw = '{OP_S_TGT,   JMP_NEXT,   PC_FIN};
            // binary search over years
            5'd12: cw = '{OP_S_TEST,  JMP_FLAG,   PC_S_EXIT};
            5'd13: cw = '{OP_YA,      JMP_NEXT,   PC_FIN};
            5'd14: cw = '{OP_YB,      JMP_NEXT,   PC_FIN};
            5'd15: cw = '{OP_S_UPD,   JMP_ALWAYS, PC_S_TEST};
            // remainder within the year, then month walk
            5'd16: cw = '{OP_S_LDLO,  JMP_NEXT,   PC_FIN};
            5'd17: cw = '{OP_YA,      JMP_NEXT,   PC_FIN};
            5'd18: cw = '{OP_YB,      JMP_NEXT,   PC_FIN};
            5'd19: cw = '{OP_S_REM,   JMP_NEXT,   PC_FIN};
            5'd20: cw = '{OP_S_CHK,   JMP_FLAG,   PC_FIN};
            5'd21: cw = '{OP_S_MON,   JMP_FLAG,   PC_S_MON};
            5'd22: cw = '{OP_FIN,     JMP_NEXT,   PC_FIN};
            default: cw = '{OP_FIN,   JMP_ALWAYS, PC_FIN};
        endcase
        return cw;
    endfunction

    // days in a month, zero for a month code outside the year
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                       input logic leap);
        logic [DAY_W-1:0] d;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:    d = leap ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [YLEN_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
        logic [YLEN_W-1:0] c;
        case (month)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

### design/dsdc_year_unit.sv
module dsdc_year_unit (
    input  logic                        clk,
    input  logic [dsdc_pkg::YEAR_W-1:0] year,
    input  dsdc_pkg::yu_ctrl_t          ctrl,
    output dsdc_pkg::yu_res_t           res
);
    import dsdc_pkg::*;

    logic [YEAR_W-1:0] prev_year;
    logic [Q4_W-1:0]   q4;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [Q100_W-1:0] q100;
    logic [Q4_W-1:0]   q100_x25;
    logic [Q4_W-1:0]   r25_full;
    logic [R25_W-1:0]  r25;
    logic              century;
    logic              quad_century;
    logic [DBY_W-1:0]  sum;
    yu_res_t           res_reg;
    yu_res_t           res_next;

    // stage a: (y-1)/4 times the reciprocal of 25
    always_comb
    begin
        prev_year = year - YEAR_W'(1);
        q4        = prev_year[YEAR_W-1:2];
        prod_next = PROD_W'(q4) * PROD_W'(DIV25_MUL);
    end

    // stage b: days before the year and the leap flag
    always_comb
    begin
        q100         = prod_reg[DIV25_SHIFT +: Q100_W];
        q100_x25     = (Q4_W'(q100) << 4) + (Q4_W'(q100) << 3) + Q4_W'(q100);
        r25_full     = q4 - q100_x25;
        r25          = r25_full[R25_W-1:0];
        century      = (r25 == R25_W'(CENTURY_R25));
        quad_century = (q100[1:0] == 2'b11);
        sum          = DBY_W'(year) * DBY_W'(DAYS_COMMON) + DBY_W'(q4) - DBY_W'(q100)
                     + DBY_W'(q100[Q100_W-1:2]) + DBY_W'(1);
        res_next.dby  = (year == '0) ? '0 : sum;
        res_next.leap = (year == '0)
                     || ((year[1:0] == 2'b00) && (!century || quad_century));
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (ctrl.stage_a)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.stage_b)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### design/date_serial_day_conversion_top.sv
// date to serial: year unit and date check; a valid date then has the base count subtracted
// serial to date: a binary search over years (up to 14 halvings) through the shared year
// unit, then a month walk
// throughput: one item at a time; the next transfer in is taken once the result moves
// to the output register, which may still wait for out_ready
// reset: asynchronous active low, base_year returns to 1, no result pending
module date_serial_day_conversion_top #(
    parameter int MAX_YEAR = dsdc_pkg::MAX_YEAR_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsdc_pkg::YEAR_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [dsdc_pkg::DAY_W-1:0]    day_in,
    input  logic [dsdc_pkg::MONTH_W-1:0]  month_in,
    input  logic [dsdc_pkg::YEAR_W-1:0]   year_in,
    input  logic [dsdc_pkg::SERIAL_W-1:0] serial_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dsdc_pkg::SERIAL_W-1:0] serial_out,
    output logic [dsdc_pkg::DAY_W-1:0]    day_out,
    output logic [dsdc_pkg::MONTH_W-1:0]  month_out,
    output logic [dsdc_pkg::YEAR_W-1:0]   year_out,
    output logic                          error
);
    import dsdc_pkg::*;

    localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);

    // control state
    logic [YEAR_W-1:0]   base_reg;
    logic [YEAR_W-1:0]   base_next;
    logic                busy_reg;
    logic                busy_next;
    logic [PC_W-1:0]     pc_reg;
    logic [PC_W-1:0]     pc_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // latched request
    logic                cmd_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  mon_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [SERIAL_W-1:0] serial_reg;

    // datapath
    logic [YEAR_W-1:0]   yarg_reg;
    logic [YEAR_W-1:0]   yarg_next;
    logic [DBY_W-1:0]    acc_reg;
    logic [DBY_W-1:0]    acc_next;
    logic [YEAR_W-1:0]   lo_reg;
    logic [YEAR_W-1:0]   lo_next;
    logic [YEAR_W-1:0]   hi_reg;
    logic [YEAR_W-1:0]   hi_next;
    logic [MONTH_W-1:0]  m_reg;
    logic [MONTH_W-1:0]  m_next;
    logic                err_reg;
    logic                err_next;

    // result register
    logic [SERIAL_W-1:0] serial_out_reg;
    logic [SERIAL_W-1:0] serial_out_next;
    logic [DAY_W-1:0]    day_out_reg;
    logic [DAY_W-1:0]    day_out_next;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [MONTH_W-1:0]  month_out_next;
    logic [YEAR_W-1:0]   year_out_reg;
    logic [YEAR_W-1:0]   year_out_next;
    logic                error_out_reg;
    logic                error_out_next;

    ucw_t                ucw;
    logic                flag;
    logic                fin;
    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic [YEAR_W:0]     mid_sum;
    logic [YEAR_W-1:0]   mid;
    logic [DAY_W-1:0]    dim_date;
    logic [DAY_W-1:0]    dim_walk;
    logic [YLEN_W-1:0]   year_len;
    logic                date_bad;
    logic                leap_adj;
    yu_ctrl_t            yu_ctrl;
    yu_res_t             yu_res;

    // shared year unit
    dsdc_year_unit u_year (
        .clk  (clk),
        .year (yarg_reg),
        .ctrl (yu_ctrl),
        .res  (yu_res)
    );

    // handshake
    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // microcode fetch
    assign ucw = ucode_rom(pc_reg);

    // datapath step
    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + (YEAR_W + 1)'(1);
        mid      = mid_sum[YEAR_W:1];
        dim_date = days_in_month(mon_reg, yu_res.leap);
        dim_walk = days_in_month(m_reg, yu_res.leap);
        year_len = yu_res.leap ? YLEN_W'(DAYS_LEAP) : YLEN_W'(DAYS_COMMON);
        leap_adj = yu_res.leap && (mon_reg > 4'd2);
        date_bad = (mon_reg == '0) || (mon_reg > MONTH_W'(MONTHS))
                || (year_reg < base_reg) || (year_reg > MAX_YEAR_V)
                || (day_reg == '0) || (day_reg > dim_date);

        yarg_next = yarg_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        m_next    = m_reg;
        err_next  = err_reg;
        flag      = 1'b0;
        fin       = 1'b0;
        yu_ctrl   = '0;

        if (busy_reg)
        begin
            case (ucw.op)
                OP_LD_YEAR:
                begin
                    yarg_next = year_reg;
                end
                OP_YA:
                begin
                    yu_ctrl.stage_a = 1'b1;
                end
                OP_YB:
                begin
                    yu_ctrl.stage_b = 1'b1;
                end
                OP_D_CHK:
                begin
                    flag     = date_bad;
                    err_next = date_bad;
                    acc_next = yu_res.dby + DBY_W'(cum_days(mon_reg)) + DBY_W'(leap_adj)
                             + DBY_W'(day_reg) - DBY_W'(1);
                end
                OP_LD_BASE:
                begin
                    yarg_next = base_reg;
                end
                OP_D_SUB:
                begin
                    acc_next = acc_reg - yu_res.dby;
                end
                OP_S_INIT:
                begin
                    flag      = (base_reg > MAX_YEAR_V);
                    err_next  = flag;
                    yarg_next = base_reg;
                    lo_next   = base_reg;
                    hi_next   = MAX_YEAR_V;
                end
                OP_S_TGT:
                begin
                    acc_next = yu_res.dby + DBY_W'(serial_reg);
                end
                OP_S_TEST:
                begin
                    flag      = (lo_reg >= hi_reg);
                    yarg_next = mid;
                end
                OP_S_UPD:
                begin
                    if (yu_res.dby <= acc_reg)
                    begin
                        lo_next = yarg_reg;
                    end
                    else
                    begin
                        hi_next = yarg_reg - YEAR_W'(1);
                    end
                end
                OP_S_LDLO:
                begin
                    yarg_next = lo_reg;
                end
                OP_S_REM:
                begin
                    acc_next = acc_reg - yu_res.dby;
                    m_next   = MONTH_W'(1);
                end
                OP_S_CHK:
                begin
                    flag     = (acc_reg >= DBY_W'(year_len));
                    err_next = flag;
                end
                OP_S_MON:
                begin
                    flag = (m_reg < MONTH_W'(MONTHS)) && (acc_reg >= DBY_W'(dim_walk));
                    if (flag)
                    begin
                        acc_next = acc_reg - DBY_W'(dim_walk);
                        m_next   = m_reg + MONTH_W'(1);
                    end
                end
                OP_FIN:
                begin
                    fin = 1'b1;
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        load_out  = 1'b0;
        if (in_fire)
        begin
            busy_next = 1'b1;
            pc_next   = command ? PC_S_ENTRY : PC_D_ENTRY;
        end
        else if (busy_reg)
        begin
            if (fin)
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else
            begin
                case (ucw.jmp)
                    JMP_ALWAYS: pc_next = ucw.target;
                    JMP_FLAG:   pc_next = flag ? ucw.target : pc_reg + PC_W'(1);
                    default:    pc_next = pc_reg + PC_W'(1);
                endcase
            end
        end
    end

    // result assembly, output valid and base year update
    always_comb
    begin
        if (!cmd_reg)
        begin
            serial_out_next = err_reg ? '0 : acc_reg[SERIAL_W-1:0];
            day_out_next    = day_reg;
            month_out_next  = mon_reg;
            year_out_next   = year_reg;
        end
        else if (err_reg)
        begin
            serial_out_next = '0;
            day_out_next    = '0;
            month_out_next  = '0;
            year_out_next   = '0;
        end
        else
        begin
            serial_out_next = serial_reg;
            day_out_next    = acc_reg[DAY_W-1:0] + DAY_W'(1);
            month_out_next  = m_reg;
            year_out_next   = lo_reg;
        end
        error_out_next = err_reg;
        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        base_next      = cfg_we ? cfg_data : base_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= YEAR_W'(BASE_YEAR_RST);
            busy_reg      <= 1'b0;
            pc_reg        <= PC_D_ENTRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request, datapath and result registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= command;
            day_reg    <= day_in;
            mon_reg    <= month_in;
            year_reg   <= year_in;
            serial_reg <= serial_in;
        end
        yarg_reg <= yarg_next;
        acc_reg  <= acc_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        m_reg    <= m_next;
        err_reg  <= err_next;
        if (load_out)
        begin
            serial_out_reg <= serial_out_next;
            day_out_reg    <= day_out_next;
            month_out_reg  <= month_out_next;
            year_out_reg   <= year_out_next;
            error_out_reg  <= error_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign serial_out = serial_out_reg;
    assign day_out    = day_out_reg;
    assign month_out  = month_out_reg;
    assign year_out   = year_out_reg;
    assign error      = error_out_reg;

`ifndef NO_ASSERTIONS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= PC_FIN)
        else $error("program counter beyond the last step");

    a_accept_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && (pc_reg == PC_D_ENTRY || pc_reg == PC_S_ENTRY))
        else $error("transfer in did not start a program");

    a_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && ucw.op == OP_S_MON |-> m_reg >= MONTH_W'(1) && m_reg <= MONTH_W'(MONTHS))
        else $error("month counter out of range");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && ucw.op == OP_S_TEST |-> lo_reg <= hi_reg)
        else $error("year search bounds crossed");

    a_result_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |->
            month_out >= MONTH_W'(1) && month_out <= MONTH_W'(MONTHS) && day_out != '0)
        else $error("valid result without a proper date");
`endif

endmodule

### tb/tb_date_serial_day_conversion_top.sv
module tb_date_serial_day_conversion_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsdc_pkg::*;

    localparam int unsigned LAST_YEAR = MAX_YEAR_DEF;
    localparam logic CMD_TO_SERIAL = 1'b0;
    localparam logic CMD_TO_DATE   = 1'b1;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_PER_BASE = 170;
    localparam int RANDOM_BASES    = 8;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_TRICKLE} rx_mode_t;

    typedef struct packed {
        logic                command;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [SERIAL_W-1:0] serial;
    } date_request_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic                error;
    } date_result_t;

    localparam int REQ_W = $bits(date_request_t);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [YEAR_W-1:0]   cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                command   = 1'b0;
    logic [DAY_W-1:0]    day_in    = '0;
    logic [MONTH_W-1:0]  month_in  = '0;
    logic [YEAR_W-1:0]   year_in   = '0;
    logic [SERIAL_W-1:0] serial_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SERIAL_W-1:0] serial_out;
    logic [DAY_W-1:0]    day_out;
    logic [MONTH_W-1:0]  month_out;
    logic [YEAR_W-1:0]   year_out;
    logic                error;

    // predictor copy of the base year register
    int unsigned base_year_q = BASE_YEAR_RST;

    date_result_t pending_conversions[$];
    date_result_t oldest_conversion;
    date_request_t seen_request;
    int mismatch_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int unsigned stall_tick = 0;
    rx_mode_t rx_mode = RX_OPEN;

    date_serial_day_conversion_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .day_in     (day_in),
        .month_in   (month_in),
        .year_in    (year_in),
        .serial_in  (serial_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .serial_out (serial_out),
        .day_out    (day_out),
        .month_out  (month_out),
        .year_out   (year_out),
        .error      (error)
    );

    always #5 clk = ~clk;

    // gregorian calendar arithmetic
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // days in years 0 up to y-1, year 0 being leap
    function automatic int unsigned days_to_year(input int unsigned y);
        if (y == 0)
            return 0;
        return 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    endfunction

    function automatic int unsigned last_serial();
        return days_to_year(LAST_YEAR + 1) - days_to_year(base_year_q) - 1;
    endfunction

    // expected conversion for one request under the current base year
    function automatic date_result_t convert_request(input date_request_t r);
        date_result_t res;
        int unsigned acc, tgt, lo, hi, mid, rem, m;
        res = '0;
        if (r.command == CMD_TO_SERIAL) begin
            res.day   = r.day;
            res.month = r.month;
            res.year  = r.year;
            if (r.month < 1 || r.month > 12 || r.year < base_year_q || r.year > LAST_YEAR ||
                r.day < 1 || r.day > month_len(r.month, r.year)) begin
                res.error = 1'b1;
            end
            else begin
                acc = days_to_year(r.year) - days_to_year(base_year_q);
                for (m = 1; m < r.month; m++)
                    acc += month_len(m, r.year);
                res.serial = SERIAL_W'(acc + r.day - 1);
            end
        end
        else if (base_year_q > LAST_YEAR) begin
            res.error = 1'b1;
        end
        else begin
            // find the last year starting on or before the target day
            tgt = days_to_year(base_year_q) + r.serial;
            lo  = base_year_q;
            hi  = LAST_YEAR;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (days_to_year(mid) <= tgt)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            rem = tgt - days_to_year(lo);
            if (rem >= (leap_year(lo) ? 366 : 365)) begin
                res.error = 1'b1;
            end
            else begin
                m = 1;
                while (m < 12 && rem >= month_len(m, lo)) begin
                    rem -= month_len(m, lo);
                    m++;
                end
                res.serial = r.serial;
                res.day    = DAY_W'(rem + 1);
                res.month  = MONTH_W'(m);
                res.year   = YEAR_W'(lo);
            end
        end
        return res;
    endfunction

    // valid date at or after the base, biased toward edges of the range
    function automatic date_request_t random_valid_date();
        date_request_t r;
        int unsigned y, m, len;
        r = REQ_W'({$urandom, $urandom});
        r.command = CMD_TO_SERIAL;
        case ($urandom_range(0, 4))
            0:       y = base_year_q + $urandom_range(0, 3);
            1:       y = LAST_YEAR - $urandom_range(0, 3);
            2:       y = 100 * $urandom_range((base_year_q + 99) / 100, LAST_YEAR / 100);
            default: y = $urandom_range(base_year_q, LAST_YEAR);
        endcase
        if (y < base_year_q)
            y = base_year_q;
        if (y > LAST_YEAR)
            y = LAST_YEAR;
        m   = $urandom_range(1, 12);
        len = month_len(m, y);
        case ($urandom_range(0, 2))
            0:       r.day = DAY_W'(1);
            1:       r.day = DAY_W'(len);
            default: r.day = DAY_W'($urandom_range(1, len));
        endcase
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    // random request: mostly well-formed, the rest noise or near misses
    function automatic date_request_t random_request();
        date_request_t r;
        date_request_t d;
        date_result_t probe;
        int unsigned last;
        r = REQ_W'({$urandom, $urandom});
        r.command = 1'($urandom_range(0, 1));
        if (base_year_q > LAST_YEAR)
            return r;
        if (r.command == CMD_TO_SERIAL) begin
            case ($urandom_range(0, 7))
                0: ;
                1: begin
                    // one day past the end of the month
                    d = random_valid_date();
                    r.day   = DAY_W'(month_len(d.month, d.year) + 1);
                    r.month = d.month;
                    r.year  = d.year;
                end
                default: begin
                    d = random_valid_date();
                    r.day   = d.day;
                    r.month = d.month;
                    r.year  = d.year;
                end
            endcase
        end
        else begin
            last = last_serial();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r.serial = SERIAL_W'($urandom_range(0, last));
                4, 5, 6: begin
                    // around a month boundary
                    d = random_valid_date();
                    probe = convert_request(d);
                    r.serial = SERIAL_W'(probe.serial + $urandom_range(0, 2) - 1);
                end
                7:       r.serial = SERIAL_W'(last - 2 + $urandom_range(0, 4));
                default: ;
            endcase
        end
        return r;
    endfunction

    // sender: bursts of transfers separated by random gaps
    task automatic send_request(input date_request_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        command   <= r.command;
        day_in    <= r.day;
        month_in  <= r.month;
        year_in   <= r.year;
        serial_in <= r.serial;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_date(input int unsigned d, input int unsigned m, input int unsigned y);
        date_request_t r;
        r = REQ_W'({$urandom, $urandom});
        r.command = CMD_TO_SERIAL;
        r.day     = DAY_W'(d);
        r.month   = MONTH_W'(m);
        r.year    = YEAR_W'(y);
        send_request(r);
    endtask

    task automatic send_serial(input int unsigned s);
        date_request_t r;
        r = REQ_W'({$urandom, $urandom});
        r.command = CMD_TO_DATE;
        r.serial  = SERIAL_W'(s);
        send_request(r);
    endtask

    // hold the sender until every pending conversion has come back
    task automatic wait_all_done();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_conversions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base_year(input int unsigned value);
        wait_all_done();
        cfg_we      <= 1'b1;
        cfg_data    <= YEAR_W'(value);
        base_year_q = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // date checks under the reset base year
    task automatic test_date_checks();
        write_base_year(BASE_YEAR_RST);
        send_date(1, 1, 1);
        send_date(31, 12, LAST_YEAR);
        send_date(0, 1, 2000);
        send_date(31, 4, 2000);
        send_date(29, 2, 2000);
        send_date(29, 2, 1900);
        send_date(29, 2, 2024);
        send_date(1, 0, 2000);
        send_date(1, 15, 2000);
        send_date(1, 1, 0);
        send_date(1, 1, LAST_YEAR + 1);
        send_date(31, 15, 16383);
    endtask

    // serial checks including past the last supported year
    task automatic test_serial_checks();
        send_serial(0);
        send_serial(59);
        send_serial(last_serial());
        send_serial(last_serial() + 1);
        send_serial((1 << SERIAL_W) - 1);
    endtask

    // lowest, highest and out of range base years
    task automatic test_base_extremes();
        write_base_year(0);
        send_date(29, 2, 0);
        send_serial(59);
        send_serial(last_serial());
        send_serial(last_serial() + 1);
        write_base_year(LAST_YEAR);
        send_date(1, 1, LAST_YEAR - 1);
        send_serial(364);
        send_serial(365);
        // base beyond the last year: everything errors
        write_base_year((1 << YEAR_W) - 1);
        send_date(1, 1, LAST_YEAR);
        send_serial(0);
    endtask

    // random conversions over a series of base years
    task automatic test_random_conversions();
        int unsigned bases[RANDOM_BASES];
        bases = '{1, 0, LAST_YEAR, 1600, 1900, 2000, 0, 0};
        for (int i = 0; i < RANDOM_BASES; i++) begin
            if (i >= 6)
                bases[i] = $urandom_range(0, LAST_YEAR);
            write_base_year(bases[i]);
            repeat (RANDOM_PER_BASE)
                send_request(random_request());
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: ready pattern switches among open, random and trickle modes
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
            default:   out_ready <= (stall_tick % 8 == 0);
        endcase
    end

    // scoreboard: output transfers first, they belong to older requests
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_conversions.size() == 0) begin
                    $error("result transfer with no conversion pending");
                    mismatch_count++;
                end
                else begin
                    oldest_conversion = pending_conversions.pop_front();
                    check_field("serial_out", 32'(oldest_conversion.serial), 32'(serial_out));
                    check_field("day_out", 32'(oldest_conversion.day), 32'(day_out));
                    check_field("month_out", 32'(oldest_conversion.month), 32'(month_out));
                    check_field("year_out", 32'(oldest_conversion.year), 32'(year_out));
                    check_field("error", 32'(oldest_conversion.error), 32'(error));
                end
            end
            if (in_valid && in_ready) begin
                seen_request.command = command;
                seen_request.day     = day_in;
                seen_request.month   = month_in;
                seen_request.year    = year_in;
                seen_request.serial  = serial_in;
                pending_conversions.push_back(convert_request(seen_request));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_date_checks();
        test_serial_checks();
        test_base_extremes();
        test_random_conversions();
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_conversions.size() != 0) begin
            $error("%0d conversions never returned", pending_conversions.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
